/* sv/rrc_pkg.sv */
`timescale 1ns / 1ps

package rrc_pkg;

  // pixel coordinate width on the result channel
  localparam int COORD_BITS = 11;

  localparam int RAY_COUNT_DEF = 360;
  localparam int FRAC_BITS_DEF = 16;

  localparam int PIX_IN_W = 11;
  localparam int RADIUS_W = 10;
  localparam int RAY_NUM_W = 10;
  localparam int SCREEN_W = 12;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST = 12'd1200;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd680;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic                action;
    logic [PIX_IN_W-1:0] light_x;
    logic [PIX_IN_W-1:0] light_y;
    logic [PIX_IN_W-1:0] obstacle_x;
    logic [PIX_IN_W-1:0] obstacle_y;
    logic [RADIUS_W-1:0] obstacle_r;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic [RAY_NUM_W-1:0]  ray_number;
    logic                  ray_done;
    logic                  frame_done;
  } out_t;

endpackage

/* sv/radial_ray_caster_circle_occluder.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_data_i  (rrc_pkg::in_t)
// out       output     out_valid_o / out_ready_i  out_data_o (rrc_pkg::out_t)
// cfg       input      cfg_we_i, cfg_idx_i        cfg_data_i (screen width / height)
//
// one item per clock when not stalled: each transfer gives exactly one result in the
// next cycle, after occluder test (3 squares, add, compare) and march-position add.
// input is taken whenever the result register is empty or being drained, so a
// stalled output only holds the input while its result waits.
// reset leaves the caster idle with a 1200 x 680 screen; no clearing pass.

module radial_ray_caster_circle_occluder #(
  parameter int RAY_COUNT = rrc_pkg::RAY_COUNT_DEF,
  parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rrc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rrc_pkg::SCREEN_W-1:0]  cfg_data_i
);
  import rrc_pkg::*;

  localparam int AW = $clog2(RAY_COUNT);
  localparam int MW = FRAC_BITS + 13;
  localparam int DW = FRAC_BITS + 2;
  localparam logic [AW-1:0] LAST_RAY = AW'(RAY_COUNT - 1);

  logic running_q, running_d;
  logic [AW-1:0] ray_q, ray_d;
  logic signed [MW-1:0] mx_q, mx_d, my_q, my_d;
  logic [PIX_IN_W-1:0] sx_q, sx_d, sy_q, sy_d, ox_q, ox_d, oy_q, oy_d;
  logic [RADIUS_W-1:0] or_q, or_d;
  logic [SCREEN_W-1:0] width_q, height_q;
  out_t out_q, out_d;
  logic out_valid_q;

  logic signed [DW-1:0] dir_cos, dir_sin;
  logic in_fire, on_screen, hit, ray_end, last_ray;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire = in_valid_i && in_ready_o;
  assign last_ray = (ray_q == LAST_RAY);

  // direction for the ray that is current after this edge
  rrc_dir_rom #(
    .RAY_COUNT(RAY_COUNT),
    .FRAC_BITS(FRAC_BITS)
  ) u_dir_rom (
    .clk_i (clk_i),
    .addr_i(ray_d),
    .cos_o (dir_cos),
    .sin_o (dir_sin)
  );

  rrc_occl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_occl (
    .pos_x_i   (mx_q),
    .pos_y_i   (my_q),
    .center_x_i(ox_q),
    .center_y_i(oy_q),
    .radius_i  (or_q),
    .hit_o     (hit)
  );

  always_comb begin
    // nonnegative positions compare on the integer part alone
    on_screen = !mx_q[MW-1] && !my_q[MW-1] &&
                (mx_q[MW-2:FRAC_BITS] < width_q) && (my_q[MW-2:FRAC_BITS] < height_q);
    ray_end = !on_screen || hit;

    running_d = running_q;
    ray_d = ray_q;
    mx_d = mx_q;
    my_d = my_q;
    sx_d = sx_q;
    sy_d = sy_q;
    ox_d = ox_q;
    oy_d = oy_q;
    or_d = or_q;
    out_d = '0;

    if (in_fire) begin
      if (in_data_i.action == ACT_START) begin
        sx_d = in_data_i.light_x;
        sy_d = in_data_i.light_y;
        ox_d = in_data_i.obstacle_x;
        oy_d = in_data_i.obstacle_y;
        or_d = in_data_i.obstacle_r;
        running_d = 1'b1;
        ray_d = '0;
        mx_d = {2'b00, in_data_i.light_x, {FRAC_BITS{1'b0}}};
        my_d = {2'b00, in_data_i.light_y, {FRAC_BITS{1'b0}}};
      end else if (!running_q) begin
        out_d.ray_number = RAY_NUM_W'(ray_q);
        out_d.frame_done = 1'b1;
      end else begin
        out_d.ray_number = RAY_NUM_W'(ray_q);
        if (ray_end) begin
          out_d.ray_done = 1'b1;
          if (last_ray) begin
            running_d = 1'b0;
            out_d.frame_done = 1'b1;
          end else begin
            ray_d = ray_q + AW'(1);
            mx_d = {2'b00, sx_q, {FRAC_BITS{1'b0}}};
            my_d = {2'b00, sy_q, {FRAC_BITS{1'b0}}};
          end
        end else begin
          out_d.pixel_x = mx_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
          out_d.pixel_y = my_q[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
          out_d.pixel_valid = 1'b1;
          mx_d = mx_q + {{(MW-DW){dir_cos[DW-1]}}, dir_cos};
          my_d = my_q + {{(MW-DW){dir_sin[DW-1]}}, dir_sin};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      ray_q <= '0;
      mx_q <= '0;
      my_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      or_q <= '0;
      width_q <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
      out_valid_q <= 1'b0;
    end else begin
      running_q <= running_d;
      ray_q <= ray_d;
      mx_q <= mx_d;
      my_q <= my_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      or_q <= or_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCREEN_WIDTH:  width_q <= cfg_data_i;
          REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // a lit pixel never also closes a ray or a frame
  a_pixel_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.pixel_valid && (out_data_o.ray_done || out_data_o.frame_done)))
    else $error("pixel result also flags ray or frame end");

  a_ray_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray_q <= LAST_RAY)
    else $error("ray index beyond last ray");

  // the end of the last ray stops the frame
  a_frame_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.action == ACT_STEP && running_q && ray_end && last_ray)
      |=> (!running_q && out_valid_o && out_data_o.frame_done))
    else $error("frame did not stop after last ray");

endmodule

/* sv/rrc_dir_rom.sv */
`timescale 1ns / 1ps

module rrc_dir_rom #(
  parameter int RAY_COUNT = rrc_pkg::RAY_COUNT_DEF,
  parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF,
  localparam int AW = $clog2(RAY_COUNT),
  localparam int DW = FRAC_BITS + 2
) (
  input  logic                 clk_i,
  input  logic [AW-1:0]        addr_i,
  output logic signed [DW-1:0] cos_o,
  output logic signed [DW-1:0] sin_o
);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic [2*DW-1:0] tab_t [RAY_COUNT];

  function automatic logic [63:0] next_term(input logic [63:0] t, input logic [63:0] phi);
    logic [63:0] p;
    p = (t * phi) >> 30;
    return (p * phi) >> 30;
  endfunction

  function automatic logic [63:0] clamp_q30(input longint v);
    logic [63:0] r;
    if (v < 0) r = 64'd0;
    else if (v > longint'(Q30_ONE)) r = Q30_ONE;
    else r = 64'(v);
    return r;
  endfunction

  function automatic logic signed [DW-1:0] round_dir(input logic [63:0] mag, input logic neg);
    logic [63:0] r;
    logic signed [DW-1:0] v;
    r = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    v = DW'(r);
    return neg ? -v : v;
  endfunction

  // cos/sin of 2*pi*i/RAY_COUNT: quadrant split, then a 10-term taylor series in q30
  function automatic tab_t build_table();
    tab_t tab;
    logic [63:0] q, rest, phi, ts, tc, ps, pc, c, s;
    longint sum_s, sum_c;
    logic signed [DW-1:0] vc, vs;
    for (int i = 0; i < RAY_COUNT; i++) begin
      q = 64'(4 * i) / RAY_COUNT;
      rest = 64'(4 * i) - q * RAY_COUNT;
      phi = (PI_HALF_Q30 * rest) / RAY_COUNT;
      ts = phi;
      tc = Q30_ONE;
      sum_s = 0;
      sum_c = 0;
      for (int k = 0; k < 10; k++) begin
        if (k % 2 == 1) begin
          sum_s = sum_s - longint'(ts);
          sum_c = sum_c - longint'(tc);
        end else begin
          sum_s = sum_s + longint'(ts);
          sum_c = sum_c + longint'(tc);
        end
        ps = next_term(ts, phi);
        pc = next_term(tc, phi);
        case (k)
          0: begin ts = ps / 6;   tc = pc / 2;   end
          1: begin ts = ps / 20;  tc = pc / 12;  end
          2: begin ts = ps / 42;  tc = pc / 30;  end
          3: begin ts = ps / 72;  tc = pc / 56;  end
          4: begin ts = ps / 110; tc = pc / 90;  end
          5: begin ts = ps / 156; tc = pc / 132; end
          6: begin ts = ps / 210; tc = pc / 182; end
          7: begin ts = ps / 272; tc = pc / 240; end
          8: begin ts = ps / 342; tc = pc / 306; end
          default: begin ts = ps / 420; tc = pc / 380; end
        endcase
      end
      c = clamp_q30(sum_c);
      s = clamp_q30(sum_s);
      case (q[1:0])
        2'd0: begin vc = round_dir(c, 1'b0); vs = round_dir(s, 1'b0); end
        2'd1: begin vc = round_dir(s, 1'b1); vs = round_dir(c, 1'b0); end
        2'd2: begin vc = round_dir(c, 1'b1); vs = round_dir(s, 1'b1); end
        default: begin vc = round_dir(s, 1'b0); vs = round_dir(c, 1'b1); end
      endcase
      tab[i] = {vc, vs};
    end
    return tab;
  endfunction

  localparam tab_t DirTable = build_table();

  logic [2*DW-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= DirTable[addr_i];
  end

  assign cos_o = entry_q[2*DW-1:DW];
  assign sin_o = entry_q[DW-1:0];

endmodule

/* sv/rrc_occl.sv */
`timescale 1ns / 1ps

module rrc_occl #(
  parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF,
  localparam int MW = FRAC_BITS + 13
) (
  input  logic signed [MW-1:0]              pos_x_i,
  input  logic signed [MW-1:0]              pos_y_i,
  input  logic [rrc_pkg::PIX_IN_W-1:0]      center_x_i,
  input  logic [rrc_pkg::PIX_IN_W-1:0]      center_y_i,
  input  logic [rrc_pkg::RADIUS_W-1:0]      radius_i,
  output logic                              hit_o
);
  import rrc_pkg::*;

  localparam int SW = FRAC_BITS + RADIUS_W;   // magnitude width below the radius limit
  localparam int QW = 2 * SW + 1;

  logic signed [MW:0] dx, dy;
  logic [MW:0] ax, ay;
  logic [MW:0] lim;
  logic near_x, near_y;
  logic [2*SW-1:0] sq_x, sq_y;
  logic [2*RADIUS_W-1:0] r_sq;
  logic [QW-1:0] dist2, rad2;

  always_comb begin
    dx = {pos_x_i[MW-1], pos_x_i} - $signed({3'b000, center_x_i, {FRAC_BITS{1'b0}}});
    dy = {pos_y_i[MW-1], pos_y_i} - $signed({3'b000, center_y_i, {FRAC_BITS{1'b0}}});
    ax = dx[MW] ? -dx : dx;
    ay = dy[MW] ? -dy : dy;
    lim = (MW + 1)'({radius_i, {FRAC_BITS{1'b0}}});
    near_x = ax < lim;
    near_y = ay < lim;
    // both magnitudes fit in SW bits once below the limit
    sq_x = ax[SW-1:0] * ax[SW-1:0];
    sq_y = ay[SW-1:0] * ay[SW-1:0];
    dist2 = QW'(sq_x) + QW'(sq_y);
    r_sq = (2 * RADIUS_W)'(radius_i) * (2 * RADIUS_W)'(radius_i);
    rad2 = QW'({r_sq, {(2 * FRAC_BITS){1'b0}}});
    hit_o = near_x && near_y && (dist2 < rad2);
  end

endmodule
